// ===== hw/rtl/fiis_pkg.sv =====
// Shared types, codes and default sizes for the Forth inner interpreter step block.
package fiis_pkg;

  localparam int DATA_STACK_DEPTH   = 32;
  localparam int RETURN_STACK_DEPTH = 32;
  localparam int CELL_BITS          = 32;
  localparam int CODE_ADDR_BITS     = 16;

  typedef enum logic [3:0] {
    OP_NOP    = 4'd0,
    OP_DEBUG  = 4'd1,
    OP_PUSH   = 4'd2,
    OP_JUMP   = 4'd3,
    OP_JZ     = 4'd4,
    OP_CALL   = 4'd5,
    OP_RET    = 4'd6,
    OP_RFROM  = 4'd7,
    OP_RFETCH = 4'd8,
    OP_TOR    = 4'd9,
    OP_NATIVE = 4'd10,
    OP_STOP   = 4'd11,
    OP_START  = 4'd13,
    OP_LIT    = 4'd14
  } fiis_op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DUNDER  = 3'd1,
    ST_DOVER   = 3'd2,
    ST_RUNDER  = 3'd3,
    ST_ROVER   = 3'd4,
    ST_BADOP   = 3'd5,
    ST_HALTED  = 3'd6
  } fiis_status_t;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] operand;
  } fiis_item_t;

  typedef struct packed {
    logic [15:0]        next_ip;
    logic               run_on;
    logic               halted;
    fiis_status_t       status;
    logic               native_call;
    logic [7:0]         native_index;
    logic [5:0]         data_depth;
    logic [5:0]         ret_depth;
    logic signed [31:0] top_cell;
  } fiis_result_t;

  // Stack command for one step.
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } fiis_stk_cmd_t;

  // Per-step flags that go straight into the result.
  typedef struct packed {
    logic         run_on;
    fiis_status_t status;
    logic         native_call;
    logic [7:0]   native_index;
  } fiis_flags_t;

endpackage

// ===== hw/rtl/forth_inner_interpreter_step.sv =====
// Top level of the Forth inner interpreter step block: channels, state and result register.
//
// Usage:
//   The item channel (item_valid / item_ready / item) carries one instruction
//   fetched at the current pointer, or an outer event (start, literal). Each
//   item yields exactly one result on the result channel (result_valid /
//   result_ready / result), in order.
//   Flow: an item is captured in the input register on its transfer and its
//   result is loaded into the result register when the step commits, which
//   needs the result register free or draining; result_valid then rises and
//   the result can transfer when the output is free.
//   Throughput: one item per cycle, sustained while result_ready stays high. The
//   limit is the state update: pointer, halt flag and the stack top and
//   next-on-stack registers close their loop, and each stack memory does one
//   write and one registered read per cycle.
//   Stall: while the receiver holds result_ready low, the result stays put and
//   one more item can still transfer into the input register; after that
//   item_ready drops until the result is taken.
//   Reset (rst, synchronous): pointer 0, both stacks empty, halt flag clear,
//   both channels empty. The stack memories are not cleared; entries above the
//   depth are never shown. Only reset clears the halt flag.
module forth_inner_interpreter_step #(
  parameter int DATA_STACK_DEPTH   = fiis_pkg::DATA_STACK_DEPTH,
  parameter int RETURN_STACK_DEPTH = fiis_pkg::RETURN_STACK_DEPTH,
  parameter int CELL_BITS          = fiis_pkg::CELL_BITS,
  parameter int CODE_ADDR_BITS     = fiis_pkg::CODE_ADDR_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  fiis_pkg::fiis_item_t   item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output fiis_pkg::fiis_result_t result
);

  localparam int DCW = $clog2(DATA_STACK_DEPTH + 1);
  localparam int RCW = $clog2(RETURN_STACK_DEPTH + 1);

  // Input register.
  logic                 held;
  fiis_pkg::fiis_item_t held_item;

  // Architectural state.
  logic [CODE_ADDR_BITS-1:0] ip;
  logic [CODE_ADDR_BITS-1:0] ip_next;
  logic                      stopped;
  logic                      stopped_next;

  // Stack interface.
  fiis_pkg::fiis_stk_cmd_t d_cmd, r_cmd, d_cmd_g, r_cmd_g;
  logic [CELL_BITS-1:0]    d_wdata, r_wdata;
  logic [DCW-1:0]          d_count, d_count_next;
  logic [RCW-1:0]          r_count, r_count_next;
  logic [CELL_BITS-1:0]    d_top, d_top_next, r_top, r_top_next;
  fiis_pkg::fiis_flags_t   flags;

  logic advance;

  // Execute the held item whenever the result register is free or draining.
  assign advance    = held && (!result_valid || result_ready);
  assign item_ready = !held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (item_valid && item_ready) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held_item <= item;
    end
  end

  fiis_exec #(
    .DATA_STACK_DEPTH   (DATA_STACK_DEPTH),
    .RETURN_STACK_DEPTH (RETURN_STACK_DEPTH),
    .CELL_BITS          (CELL_BITS),
    .CODE_ADDR_BITS     (CODE_ADDR_BITS)
  ) u_exec (
    .item         (held_item),
    .ip           (ip),
    .stopped      (stopped),
    .d_count      (d_count),
    .d_top        (d_top),
    .r_count      (r_count),
    .r_top        (r_top),
    .ip_next      (ip_next),
    .stopped_next (stopped_next),
    .d_cmd        (d_cmd),
    .d_wdata      (d_wdata),
    .r_cmd        (r_cmd),
    .r_wdata      (r_wdata),
    .flags        (flags)
  );

  // Stacks move only on a step that commits.
  assign d_cmd_g = advance ? d_cmd : '0;
  assign r_cmd_g = advance ? r_cmd : '0;

  fiis_stack #(
    .DEPTH (DATA_STACK_DEPTH),
    .WIDTH (CELL_BITS)
  ) u_dstk (
    .clk        (clk),
    .rst        (rst),
    .cmd        (d_cmd_g),
    .wdata      (d_wdata),
    .count      (d_count),
    .top        (d_top),
    .count_next (d_count_next),
    .top_next   (d_top_next)
  );

  fiis_stack #(
    .DEPTH (RETURN_STACK_DEPTH),
    .WIDTH (CELL_BITS)
  ) u_rstk (
    .clk        (clk),
    .rst        (rst),
    .cmd        (r_cmd_g),
    .wdata      (r_wdata),
    .count      (r_count),
    .top        (r_top),
    .count_next (r_count_next),
    .top_next   (r_top_next)
  );

  // Pointer and halt flag advance with the step.
  always_ff @(posedge clk) begin
    if (rst) begin
      ip      <= '0;
      stopped <= 1'b0;
    end else if (advance) begin
      ip      <= ip_next;
      stopped <= stopped_next;
    end
  end

  // Result register: hold until the transfer, load on each step.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.next_ip      <= 16'(ip_next);
      result.run_on       <= flags.run_on;
      result.halted       <= stopped_next;
      result.status       <= flags.status;
      result.native_call  <= flags.native_call;
      result.native_index <= flags.native_index;
      result.data_depth   <= 6'(d_count_next);
      result.ret_depth    <= 6'(r_count_next);
      // Show zero for an empty data stack.
      result.top_cell     <= (d_count_next == '0) ? '0 : 32'(d_top_next);
    end
  end

  // Halt flag is sticky until reset.
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped)
    else $error("halt flag cleared without reset");

  // An error result shows both stacks empty and the block halted.
  a_error_clears: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != fiis_pkg::ST_OK &&
     result.status != fiis_pkg::ST_HALTED) |->
    (result.halted && result.data_depth == '0 && result.ret_depth == '0 &&
     !result.run_on))
    else $error("error result without cleared stacks");

  // Stack depths never pass their limits.
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    (d_count <= DCW'(DATA_STACK_DEPTH)) && (r_count <= RCW'(RETURN_STACK_DEPTH)))
    else $error("stack depth beyond limit");

  // A committed step always lands in the result register.
  a_step_lands: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("step result lost");

endmodule

// ===== hw/rtl/fiis_stack.sv =====
// One hardware stack: cell memory plus registered top and next-on-stack cells.
module fiis_stack #(
  parameter int DEPTH = fiis_pkg::DATA_STACK_DEPTH,
  parameter int WIDTH = fiis_pkg::CELL_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fiis_pkg::fiis_stk_cmd_t       cmd,
  input  logic [WIDTH-1:0]              wdata,
  output logic [$clog2(DEPTH+1)-1:0]    count,
  output logic [WIDTH-1:0]              top,
  output logic [$clog2(DEPTH+1)-1:0]    count_next,
  output logic [WIDTH-1:0]              top_next
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] nos;
  logic [CW-1:0]    below_next;
  logic [IW-1:0]    rd_idx;
  logic [IW-1:0]    wr_idx;

  always_comb begin
    priority if (cmd.clear) begin
      count_next = '0;
    end else if (cmd.push) begin
      count_next = count + CW'(1);
    end else if (cmd.pop) begin
      count_next = count - CW'(1);
    end else begin
      count_next = count;
    end
  end

  always_comb begin
    priority if (cmd.push) begin
      top_next = wdata;
    end else if (cmd.pop) begin
      top_next = nos;
    end else begin
      top_next = top;
    end
  end

  // Cell below the new top: fetch it now so a following pop finds it ready.
  assign below_next = count_next - CW'(2);
  assign rd_idx     = below_next[IW-1:0];
  assign wr_idx     = count[IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_idx] <= wdata;
    end
    if (cmd.push) begin
      nos <= top;
    end else if (cmd.pop) begin
      nos <= mem[rd_idx];
    end
    top <= top_next;
  end

endmodule

// ===== hw/rtl/fiis_exec.sv =====
// Instruction decode and execute: next pointer, stack commands and result flags.
module fiis_exec #(
  parameter int DATA_STACK_DEPTH   = fiis_pkg::DATA_STACK_DEPTH,
  parameter int RETURN_STACK_DEPTH = fiis_pkg::RETURN_STACK_DEPTH,
  parameter int CELL_BITS          = fiis_pkg::CELL_BITS,
  parameter int CODE_ADDR_BITS     = fiis_pkg::CODE_ADDR_BITS
) (
  input  fiis_pkg::fiis_item_t                   item,
  input  logic [CODE_ADDR_BITS-1:0]              ip,
  input  logic                                   stopped,
  input  logic [$clog2(DATA_STACK_DEPTH+1)-1:0]  d_count,
  input  logic [CELL_BITS-1:0]                   d_top,
  input  logic [$clog2(RETURN_STACK_DEPTH+1)-1:0] r_count,
  input  logic [CELL_BITS-1:0]                   r_top,
  output logic [CODE_ADDR_BITS-1:0]              ip_next,
  output logic                                   stopped_next,
  output fiis_pkg::fiis_stk_cmd_t                d_cmd,
  output logic [CELL_BITS-1:0]                   d_wdata,
  output fiis_pkg::fiis_stk_cmd_t                r_cmd,
  output logic [CELL_BITS-1:0]                   r_wdata,
  output fiis_pkg::fiis_flags_t                  flags
);

  localparam int DCW = $clog2(DATA_STACK_DEPTH + 1);
  localparam int RCW = $clog2(RETURN_STACK_DEPTH + 1);

  fiis_pkg::fiis_op_t       op;
  logic [CELL_BITS-1:0]      operand_cell;
  logic [CODE_ADDR_BITS-1:0] addr;
  logic [CODE_ADDR_BITS-1:0] ip_inc;
  logic                      d_empty, d_full, r_empty, r_full;
  logic                      fault;

  assign op           = fiis_pkg::fiis_op_t'(item.op);
  assign operand_cell = CELL_BITS'(item.operand);
  assign addr         = item.operand[CODE_ADDR_BITS-1:0];
  assign ip_inc       = ip + CODE_ADDR_BITS'(1);
  assign d_empty      = (d_count == '0);
  assign d_full       = (d_count == DCW'(DATA_STACK_DEPTH));
  assign r_empty      = (r_count == '0);
  assign r_full       = (r_count == RCW'(RETURN_STACK_DEPTH));

  always_comb begin
    ip_next      = ip;
    stopped_next = stopped;
    d_cmd        = '0;
    r_cmd        = '0;
    d_wdata      = operand_cell;
    r_wdata      = CELL_BITS'(ip_inc);
    flags        = '0;
    flags.status = fiis_pkg::ST_OK;
    fault        = 1'b0;

    priority if (stopped) begin
      flags.status = fiis_pkg::ST_HALTED;
    end else if (op == fiis_pkg::OP_START) begin
      ip_next      = addr;
      flags.run_on = 1'b1;
    end else if (op == fiis_pkg::OP_LIT) begin
      if (d_full) begin
        flags.status = fiis_pkg::ST_DOVER;
      end else begin
        d_cmd.push = 1'b1;
      end
    end else begin
      ip_next      = ip_inc;
      flags.run_on = 1'b1;
      unique case (op)
        fiis_pkg::OP_NOP, fiis_pkg::OP_DEBUG: begin
        end
        fiis_pkg::OP_PUSH: begin
          if (d_full) begin
            flags.status = fiis_pkg::ST_DOVER;
          end else begin
            d_cmd.push = 1'b1;
          end
        end
        fiis_pkg::OP_JUMP: begin
          ip_next = addr;
        end
        fiis_pkg::OP_JZ: begin
          if (d_empty) begin
            flags.status = fiis_pkg::ST_DUNDER;
          end else begin
            d_cmd.pop = 1'b1;
            if (d_top == '0) begin
              ip_next = addr;
            end
          end
        end
        fiis_pkg::OP_CALL: begin
          if (r_full) begin
            flags.status = fiis_pkg::ST_ROVER;
          end else begin
            r_cmd.push = 1'b1;
            ip_next    = addr;
          end
        end
        fiis_pkg::OP_RET: begin
          if (r_empty) begin
            flags.run_on = 1'b0;
          end else begin
            r_cmd.pop = 1'b1;
            ip_next   = CODE_ADDR_BITS'(r_top);
          end
        end
        fiis_pkg::OP_RFROM, fiis_pkg::OP_RFETCH: begin
          if (r_empty) begin
            flags.status = fiis_pkg::ST_RUNDER;
          end else if (d_full) begin
            flags.status = fiis_pkg::ST_DOVER;
          end else begin
            d_cmd.push = 1'b1;
            d_wdata    = r_top;
            r_cmd.pop  = (op == fiis_pkg::OP_RFROM);
          end
        end
        fiis_pkg::OP_TOR: begin
          if (d_empty) begin
            flags.status = fiis_pkg::ST_DUNDER;
          end else if (r_full) begin
            flags.status = fiis_pkg::ST_ROVER;
          end else begin
            d_cmd.pop  = 1'b1;
            r_cmd.push = 1'b1;
            r_wdata    = d_top;
          end
        end
        fiis_pkg::OP_NATIVE: begin
          flags.native_call  = 1'b1;
          flags.native_index = item.operand[7:0];
        end
        fiis_pkg::OP_STOP: begin
          stopped_next = 1'b1;
          flags.run_on = 1'b0;
        end
        default: begin
          flags.status = fiis_pkg::ST_BADOP;
        end
      endcase
    end

    // Any error empties both stacks and halts.
    fault = (flags.status != fiis_pkg::ST_OK) && (flags.status != fiis_pkg::ST_HALTED);
    if (fault) begin
      d_cmd        = '0;
      r_cmd        = '0;
      d_cmd.clear  = 1'b1;
      r_cmd.clear  = 1'b1;
      stopped_next = 1'b1;
      flags.run_on = 1'b0;
    end
  end

endmodule

// ===== verif/fiis_checker.sv =====
// Predicts and checks every result of the Forth inner interpreter step block.
module fiis_checker
  import fiis_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  input  logic         item_ready,
  input  fiis_item_t   item,
  input  logic         result_valid,
  input  logic         result_ready,
  input  fiis_result_t result,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0]  ip;
  logic [31:0]  data_stack [DATA_STACK_DEPTH];
  logic [31:0]  ret_stack [RETURN_STACK_DEPTH];
  int           data_count;
  int           ret_count;
  bit           stopped;
  fiis_result_t expected_q [$];
  int           mismatches = 0;

  // Execute one item on the shadow interpreter and return the result it must produce.
  function automatic fiis_result_t interpret_item(fiis_item_t it);
    fiis_result_t r;
    fiis_status_t st;
    logic         run;
    logic         ncall;
    logic [7:0]   nidx;
    logic [15:0]  target;
    st     = ST_OK;
    run    = 1'b0;
    ncall  = 1'b0;
    nidx   = 8'd0;
    target = it.operand[15:0];
    if (stopped) begin
      st = ST_HALTED;
    end else if (it.op == OP_START) begin
      ip  = target;
      run = 1'b1;
    end else if (it.op == OP_LIT) begin
      if (data_count >= DATA_STACK_DEPTH) begin
        st = ST_DOVER;
      end else begin
        data_stack[data_count] = it.operand;
        data_count++;
      end
    end else begin
      ip  = ip + 16'd1;
      run = 1'b1;
      case (it.op)
        OP_NOP, OP_DEBUG: ;
        OP_PUSH: begin
          if (data_count >= DATA_STACK_DEPTH) begin
            st = ST_DOVER;
          end else begin
            data_stack[data_count] = it.operand;
            data_count++;
          end
        end
        OP_JUMP: ip = target;
        OP_JZ: begin
          if (data_count == 0) begin
            st = ST_DUNDER;
          end else begin
            data_count--;
            if (data_stack[data_count] == 32'd0) ip = target;
          end
        end
        OP_CALL: begin
          if (ret_count >= RETURN_STACK_DEPTH) begin
            st = ST_ROVER;
          end else begin
            ret_stack[ret_count] = {16'd0, ip};
            ret_count++;
            ip = target;
          end
        end
        OP_RET: begin
          if (ret_count == 0) begin
            run = 1'b0;
          end else begin
            ret_count--;
            ip = ret_stack[ret_count][15:0];
          end
        end
        OP_RFROM, OP_RFETCH: begin
          if (ret_count == 0) begin
            st = ST_RUNDER;
          end else if (data_count >= DATA_STACK_DEPTH) begin
            st = ST_DOVER;
          end else begin
            data_stack[data_count] = ret_stack[ret_count - 1];
            data_count++;
            if (it.op == OP_RFROM) ret_count--;
          end
        end
        OP_TOR: begin
          if (data_count == 0) begin
            st = ST_DUNDER;
          end else if (ret_count >= RETURN_STACK_DEPTH) begin
            st = ST_ROVER;
          end else begin
            data_count--;
            ret_stack[ret_count] = data_stack[data_count];
            ret_count++;
          end
        end
        OP_NATIVE: begin
          ncall = 1'b1;
          nidx  = it.operand[7:0];
        end
        OP_STOP: begin
          stopped = 1'b1;
          run     = 1'b0;
        end
        default: st = ST_BADOP;
      endcase
    end
    // Any fault empties both stacks and halts; the pointer keeps its advanced value.
    if (st != ST_OK && st != ST_HALTED) begin
      data_count = 0;
      ret_count  = 0;
      stopped    = 1'b1;
      run        = 1'b0;
    end
    r.next_ip      = ip;
    r.run_on       = run;
    r.halted       = stopped;
    r.status       = st;
    r.native_call  = ncall;
    r.native_index = nidx;
    r.data_depth   = data_count[5:0];
    r.ret_depth    = ret_count[5:0];
    r.top_cell     = (data_count != 0) ? data_stack[data_count - 1] : 32'd0;
    return r;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    fiis_result_t want;
    if (rst) begin
      ip         = 16'd0;
      data_count = 0;
      ret_count  = 0;
      stopped    = 1'b0;
      expected_q.delete();
    end else begin
      // Compare first: a result never belongs to the item transferring on the same edge.
      if (result_valid && result_ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got %h", $time, result);
        end else begin
          want = expected_q.pop_front();
          check_field("next_ip", want.next_ip, result.next_ip);
          check_field("run_on", want.run_on, result.run_on);
          check_field("halted", want.halted, result.halted);
          check_field("status", want.status, result.status);
          check_field("native_call", want.native_call, result.native_call);
          check_field("native_index", want.native_index, result.native_index);
          check_field("data_depth", want.data_depth, result.data_depth);
          check_field("ret_depth", want.ret_depth, result.ret_depth);
          check_field("top_cell", want.top_cell, result.top_cell);
        end
      end
      if (item_valid && item_ready) expected_q.push_back(interpret_item(item));
    end
    fail_count <= mismatches;
    pending    <= expected_q.size();
  end

endmodule

// ===== verif/tb_forth_inner_interpreter_step.sv =====
// Stimulus, flow control and verdict for the Forth inner interpreter step block.
module tb_forth_inner_interpreter_step;
  timeunit 1ns;
  timeprecision 1ps;
  import fiis_pkg::*;

  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         RANDOM_ITEMS  = 1880;
  localparam int         MAX_GAP       = 16;
  localparam int         HOLD_CYCLES   = 200;
  localparam int         TAIL_CYCLES   = 8;
  localparam int         IGNORED_ITEMS = 20;
  // Opcodes the block does not know.
  localparam logic [3:0] OP_UNKNOWN_LO = 4'd12;
  localparam logic [3:0] OP_UNKNOWN_HI = 4'd15;

  // Ways to end the program. The halt flag is sticky and reset happens only once,
  // so each run picks one of them for its final part.
  typedef enum int {
    END_STOP, END_BADOP, END_JZ_EMPTY, END_TOR_EMPTY, END_PUSH_FULL,
    END_LIT_FULL, END_RFETCH_FULL, END_RFROM_EMPTY, END_CALL_FULL, END_TOR_RFULL
  } halt_cause_t;

  logic         clk;
  logic         rst;
  logic         item_valid;
  logic         item_ready;
  fiis_item_t   item;
  logic         result_valid;
  logic         result_ready;
  fiis_result_t result;
  int           fail_count;
  int           pending;

  // Stack depths as the program leaves them; used only to keep programs well formed.
  int           data_level = 0;
  int           ret_level = 0;
  int           items_sent = 0;
  int           directed_items = 0;
  int           cycle_count = 0;
  bit           no_idle = 1'b0;
  bit           squeeze_req = 1'b0;
  halt_cause_t  cause;

  forth_inner_interpreter_step dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  fiis_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Idle cycles before one transfer: often none, otherwise up to MAX_GAP.
  function automatic int draw_gap();
    if (no_idle || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(1, MAX_GAP);
  endfunction

  // Operand with a strong pull toward the edges of the 32-bit range and toward zero,
  // so that jump-if-false takes its branch now and then.
  function automatic logic [31:0] rand_operand();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0:       v = 32'h0000_0000;
      1:       v = 32'hFFFF_FFFF;
      2:       v = 32'h7FFF_FFFF;
      3:       v = 32'h8000_0000;
      4:       v = 32'($urandom_range(0, 255));
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // True when the opcode would fault or halt at the current depths.
  function automatic bit would_fail(logic [3:0] code);
    case (code)
      OP_PUSH, OP_LIT:     return data_level >= DATA_STACK_DEPTH;
      OP_JZ:               return data_level == 0;
      OP_CALL:             return ret_level >= RETURN_STACK_DEPTH;
      OP_RFROM, OP_RFETCH: return ret_level == 0 || data_level >= DATA_STACK_DEPTH;
      OP_TOR:              return data_level == 0 || ret_level >= RETURN_STACK_DEPTH;
      OP_STOP, OP_UNKNOWN_LO, OP_UNKNOWN_HI: return 1'b1;
      default:             return 1'b0;
    endcase
  endfunction

  function automatic void note_depths(logic [3:0] code);
    if (would_fail(code)) return;
    case (code)
      OP_PUSH, OP_LIT, OP_RFETCH: data_level++;
      OP_JZ:    data_level--;
      OP_CALL:  ret_level++;
      OP_RET:   if (ret_level > 0) ret_level--;
      OP_RFROM: begin
        data_level++;
        ret_level--;
      end
      OP_TOR: begin
        data_level--;
        ret_level++;
      end
      default: ;
    endcase
  endfunction

  // Pick an opcode; when growing, lean on ops that deepen the stacks, else on ops
  // that drain them.
  function automatic logic [3:0] pick_op(bit grow);
    int v;
    if ($urandom_range(0, 9) < 4) begin
      case ($urandom_range(0, 3))
        0:       v = grow ? OP_PUSH : OP_JZ;
        1:       v = grow ? OP_LIT : OP_RET;
        2:       v = grow ? OP_CALL : OP_RFROM;
        default: v = grow ? OP_RFETCH : OP_TOR;
      endcase
      return v[3:0];
    end
    v = $urandom_range(0, 13);
    // Skip the unknown code that sits between stop and start.
    if (v >= OP_UNKNOWN_LO) v++;
    return v[3:0];
  endfunction

  // Offer one item after a random gap and hold it until it transfers. Valid stays
  // high across back-to-back items so it is never dropped and raised in one step.
  task automatic send_item(logic [3:0] code, logic [31:0] value);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{op: code, operand: value};
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    items_sent++;
    note_depths(code);
  endtask

  // Walk both stacks to the wanted depths with legal ops only.
  task automatic settle_depths(int want_data, int want_ret);
    while (ret_level > want_ret) send_item(OP_RET, rand_operand());
    while (ret_level < want_ret) send_item(OP_CALL, rand_operand());
    while (data_level > want_data) send_item(OP_JZ, rand_operand());
    while (data_level < want_data) send_item(OP_LIT, rand_operand());
  endtask

  // Result side: stall a random number of cycles before each result, and once hold
  // off for a long stretch so the block fills up and pushes back on its input.
  initial begin : receiver
    int stall;
    result_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = draw_gap();
        if (stall > 0) begin
          result_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [3:0] code;
    bit         grow;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: every non-halting op, operand extremes, pointer wrap, branch taken
    // and not taken, return on an empty return stack, native index truncation.
    send_item(OP_NOP, 32'h0000_0000);
    send_item(OP_DEBUG, 32'hFFFF_FFFF);
    send_item(OP_START, 32'h8000_FFFF);   // high bits of the address drop
    send_item(OP_NOP, 32'h0000_0000);     // pointer wraps to zero
    send_item(OP_LIT, 32'h7FFF_FFFF);
    send_item(OP_LIT, 32'h8000_0000);
    send_item(OP_PUSH, 32'h0000_0000);
    send_item(OP_JZ, 32'h0000_1234);      // zero on top: branch
    send_item(OP_JZ, 32'h0000_ABCD);      // nonzero on top: fall through
    send_item(OP_TOR, 32'h0000_0000);
    send_item(OP_RFETCH, 32'h0000_0000);
    send_item(OP_RFROM, 32'h0000_0000);
    send_item(OP_RET, 32'h0000_0000);     // empty return stack ends the run
    send_item(OP_CALL, 32'h0000_4000);
    send_item(OP_JUMP, 32'hFFFF_FFFF);
    send_item(OP_RET, 32'h0000_0000);
    send_item(OP_NATIVE, 32'hFFFF_FFFF);
    send_item(OP_NATIVE, 32'h0000_0100); // index wider than 8 bits truncates
    send_item(OP_LIT, 32'hFFFF_FFFF);
    send_item(OP_START, 32'h0000_0000);
    directed_items = items_sent;

    // Random well-formed programs that swing both stacks between empty and full.
    grow = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // Stretches with no idling on either side, and a flood during the long hold-off.
      no_idle = ((i % 400) >= 340) || (i >= 700 && i < 760);
      if (i == 700) squeeze_req = 1'b1;
      if (data_level == DATA_STACK_DEPTH || ret_level == RETURN_STACK_DEPTH) begin
        grow = 1'b0;
      end else if (data_level == 0 && ret_level == 0) begin
        grow = 1'b1;
      end else if ($urandom_range(0, 63) == 0) begin
        grow = !grow;
      end
      code = pick_op(grow);
      while (would_fail(code)) code = pick_op(grow);
      send_item(code, rand_operand());
    end
    no_idle = 1'b0;

    // Halt the interpreter one way or another, then show it ignores everything.
    cause = halt_cause_t'($urandom_range(END_STOP, END_TOR_RFULL));
    case (cause)
      END_STOP:  send_item(OP_STOP, rand_operand());
      END_BADOP: send_item($urandom_range(0, 1) ? OP_UNKNOWN_LO : OP_UNKNOWN_HI,
                           rand_operand());
      END_JZ_EMPTY: begin
        settle_depths(0, ret_level);
        send_item(OP_JZ, rand_operand());   // underflow must not pop
      end
      END_TOR_EMPTY: begin
        settle_depths(0, ret_level);
        send_item(OP_TOR, rand_operand());
      end
      END_PUSH_FULL: begin
        settle_depths(DATA_STACK_DEPTH, ret_level);
        send_item(OP_PUSH, rand_operand());
      end
      END_LIT_FULL: begin
        settle_depths(DATA_STACK_DEPTH, ret_level);
        send_item(OP_LIT, rand_operand());
      end
      END_RFETCH_FULL: begin
        settle_depths(DATA_STACK_DEPTH, (ret_level == 0) ? 1 : ret_level);
        send_item(OP_RFETCH, rand_operand());
      end
      END_RFROM_EMPTY: begin
        settle_depths(data_level, 0);
        send_item(OP_RFROM, rand_operand());
      end
      END_CALL_FULL: begin
        settle_depths(data_level, RETURN_STACK_DEPTH);
        send_item(OP_CALL, rand_operand());
      end
      default: begin
        settle_depths((data_level == 0) ? 1 : data_level, RETURN_STACK_DEPTH);
        send_item(OP_TOR, rand_operand());
      end
    endcase
    repeat (IGNORED_ITEMS) send_item(4'($urandom_range(0, 15)), $urandom());
    item_valid <= 1'b0;

    // Drain: wait for every predicted result, then keep watching for strays.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d transfers (%0d directed) with stacks swept from empty to full,",
             items_sent, directed_items);
    $display("ending with a halt by %s and %0d ignored items after it.",
             cause.name(), IGNORED_ITEMS);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d field mismatches", fail_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
